[hdl/dwmc_pkg.sv]
// Package for the digital watch mode controller: event and result structs,
// state and code constants, the set-mode wrap function and state/mode lookups.
// No dependencies.
package dwmc_pkg;

	typedef enum logic [12:0] {
		ST_SHOW     = 13'b0000000000001,
		ST_WSETH    = 13'b0000000000010,
		ST_WSETM    = 13'b0000000000100,
		ST_SW_STOP  = 13'b0000000001000,
		ST_SW_RUN   = 13'b0000000010000,
		ST_SW_PAUSE = 13'b0000000100000,
		ST_AL_SETH  = 13'b0000001000000,
		ST_AL_SETM  = 13'b0000010000000,
		ST_AL_RUN   = 13'b0000100000000,
		ST_TM_SETH  = 13'b0001000000000,
		ST_TM_SETM  = 13'b0010000000000,
		ST_TM_SETS  = 13'b0100000000000,
		ST_TM_RUN   = 13'b1000000000000
	} state_t;

	// Controller state codes as they appear on the result.
	localparam logic [3:0] SC_SHOW     = 4'd0;
	localparam logic [3:0] SC_WSETH    = 4'd1;
	localparam logic [3:0] SC_WSETM    = 4'd2;
	localparam logic [3:0] SC_SW_STOP  = 4'd3;
	localparam logic [3:0] SC_SW_RUN   = 4'd4;
	localparam logic [3:0] SC_SW_PAUSE = 4'd5;
	localparam logic [3:0] SC_AL_SETH  = 4'd6;
	localparam logic [3:0] SC_AL_SETM  = 4'd7;
	localparam logic [3:0] SC_AL_RUN   = 4'd8;
	localparam logic [3:0] SC_TM_SETH  = 4'd9;
	localparam logic [3:0] SC_TM_SETM  = 4'd10;
	localparam logic [3:0] SC_TM_SETS  = 4'd11;
	localparam logic [3:0] SC_TM_RUN   = 4'd12;

	localparam logic [3:0] OP_TICK   = 4'd0;
	localparam logic [3:0] OP_WATCH  = 4'd1;
	localparam logic [3:0] OP_SWATCH = 4'd2;
	localparam logic [3:0] OP_ALARM  = 4'd3;
	localparam logic [3:0] OP_TIMER  = 4'd4;
	localparam logic [3:0] OP_PLUS   = 4'd5;
	localparam logic [3:0] OP_MINUS  = 4'd6;
	localparam logic [3:0] OP_START  = 4'd7;
	localparam logic [3:0] OP_STOP   = 4'd8;

	localparam logic [2:0] ACT_NONE      = 3'd0;
	localparam logic [2:0] ACT_SW_START  = 3'd1;
	localparam logic [2:0] ACT_SW_CLEAR  = 3'd2;
	localparam logic [2:0] ACT_AL_RING   = 3'd3;
	localparam logic [2:0] ACT_AL_STOP   = 3'd4;
	localparam logic [2:0] ACT_TM_START  = 3'd5;
	localparam logic [2:0] ACT_TM_STOP   = 3'd6;

	localparam logic [2:0] TGT_NONE      = 3'd0;
	localparam logic [2:0] TGT_WATCH_HM  = 3'd1;
	localparam logic [2:0] TGT_WATCH_CLR = 3'd2;
	localparam logic [2:0] TGT_TIMER_HMS = 3'd3;
	localparam logic [2:0] TGT_TIMER_CLR = 3'd4;

	localparam logic [1:0] SWS_STOPPED = 2'd0;
	localparam logic [1:0] SWS_RUNNING = 2'd1;
	localparam logic [1:0] SWS_PAUSED  = 2'd2;

	localparam logic [1:0] MODE_WATCH  = 2'd0;
	localparam logic [1:0] MODE_SWATCH = 2'd1;
	localparam logic [1:0] MODE_ALARM  = 2'd2;
	localparam logic [1:0] MODE_TIMER  = 2'd3;

	localparam logic [5:0] HOUR_MAX = 6'd23;
	localparam logic [5:0] MIN_MAX  = 6'd59;

	// History offsets within each mode.
	localparam logic [1:0] SWH_STOP  = 2'd0;
	localparam logic [1:0] SWH_RUN   = 2'd1;
	localparam logic [1:0] SWH_PAUSE = 2'd2;
	localparam logic [1:0] ALH_SETH  = 2'd0;
	localparam logic [1:0] ALH_SETM  = 2'd1;
	localparam logic [1:0] ALH_RUN   = 2'd2;
	localparam logic [2:0] TMH_SETH  = 3'd0;
	localparam logic [2:0] TMH_RUN   = 3'd3;

	typedef struct packed {
		logic [3:0] op;
		logic [4:0] watch_hours;
		logic [5:0] watch_minutes;
		logic [4:0] timer_hours;
		logic [5:0] timer_minutes;
		logic [5:0] timer_seconds;
		logic       alarm_done;
	} evt_t;

	typedef struct packed {
		logic [3:0] state_code;
		logic [1:0] mode;
		logic       watch_setting;
		logic [1:0] swatch_run;
		logic       alarm_armed;
		logic [2:0] action;
		logic [2:0] write_target;
		logic [4:0] new_hours;
		logic [5:0] new_minutes;
		logic [5:0] new_seconds;
		logic [4:0] alarm_hours;
		logic [5:0] alarm_minutes;
	} res_t;

	// One step up or down with wraparound; out-of-range values go to 0 or max.
	function automatic logic [5:0] wrap_step(logic [5:0] v, logic [5:0] max, logic up);
		logic [5:0] r;
		if (up) begin
			r = (v >= max) ? 6'd0 : v + 6'd1;
		end else begin
			r = (v == 6'd0 || v > max) ? max : v - 6'd1;
		end
		return r;
	endfunction

	function automatic logic [3:0] state_code_f(state_t s);
		logic [3:0] c;
		case (s)
			ST_SHOW:     c = SC_SHOW;
			ST_WSETH:    c = SC_WSETH;
			ST_WSETM:    c = SC_WSETM;
			ST_SW_STOP:  c = SC_SW_STOP;
			ST_SW_RUN:   c = SC_SW_RUN;
			ST_SW_PAUSE: c = SC_SW_PAUSE;
			ST_AL_SETH:  c = SC_AL_SETH;
			ST_AL_SETM:  c = SC_AL_SETM;
			ST_AL_RUN:   c = SC_AL_RUN;
			ST_TM_SETH:  c = SC_TM_SETH;
			ST_TM_SETM:  c = SC_TM_SETM;
			ST_TM_SETS:  c = SC_TM_SETS;
			ST_TM_RUN:   c = SC_TM_RUN;
			default:     c = SC_SHOW;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] mode_f(state_t s);
		logic [1:0] m;
		case (s)
			ST_SHOW, ST_WSETH, ST_WSETM:            m = MODE_WATCH;
			ST_SW_STOP, ST_SW_RUN, ST_SW_PAUSE:     m = MODE_SWATCH;
			ST_AL_SETH, ST_AL_SETM, ST_AL_RUN:      m = MODE_ALARM;
			default:                                m = MODE_TIMER;
		endcase
		return m;
	endfunction

endpackage

[hdl/dwmc_ctrl.sv]
// Mode controller core: state, history and alarm registers plus the
// next-state and result logic for one event. Depends on dwmc_pkg.
module dwmc_ctrl import dwmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  evt_t evt,
	output res_t res
);

	state_t     st_q, st_d;
	logic [1:0] swh_q, swh_d;
	logic [1:0] alh_q, alh_d;
	logic [2:0] tmh_q, tmh_d;
	logic [4:0] alh_hr_q, alh_hr_d;
	logic [5:0] al_min_q, al_min_d;
	logic       set_q, set_d;
	logic [1:0] sws_q, sws_d;
	logic       arm_q, arm_d;

	state_t     sw_tgt, al_tgt, tm_tgt;
	logic       up, alarm_later, timer_nonzero;
	logic [2:0] act, tgt;
	logic [4:0] nh;
	logic [5:0] nm, ns;

	always_comb begin
		case (swh_q)
			SWH_RUN:   sw_tgt = ST_SW_RUN;
			SWH_PAUSE: sw_tgt = ST_SW_PAUSE;
			default:   sw_tgt = ST_SW_STOP;
		endcase
		case (alh_q)
			ALH_SETM: al_tgt = ST_AL_SETM;
			ALH_RUN:  al_tgt = ST_AL_RUN;
			default:  al_tgt = ST_AL_SETH;
		endcase
		tm_tgt = (tmh_q == TMH_RUN) ? ST_TM_RUN : ST_TM_SETH;
	end

	assign up = (evt.op == OP_PLUS);
	assign timer_nonzero = (evt.timer_hours != 5'd0) || (evt.timer_minutes != 6'd0) ||
		(evt.timer_seconds != 6'd0);
	assign alarm_later = (alh_hr_q > evt.watch_hours) ||
		(alh_hr_q == evt.watch_hours && al_min_q > evt.watch_minutes);

	always_comb begin
		st_d     = st_q;
		swh_d    = swh_q;
		alh_d    = alh_q;
		tmh_d    = tmh_q;
		alh_hr_d = alh_hr_q;
		al_min_d = al_min_q;
		set_d    = set_q;
		sws_d    = sws_q;
		arm_d    = arm_q;
		act      = ACT_NONE;
		tgt      = TGT_NONE;
		nh       = 5'd0;
		nm       = 6'd0;
		ns       = 6'd0;
		case (st_q)
			ST_SHOW: begin
				if (evt.op == OP_WATCH) begin
					set_d = 1'b1;
					st_d  = ST_WSETH;
				end else if (evt.op == OP_SWATCH) begin
					st_d = sw_tgt;
				end else if (evt.op == OP_ALARM) begin
					st_d = al_tgt;
				end else if (evt.op == OP_TIMER) begin
					st_d = tm_tgt;
				end
			end
			ST_WSETH, ST_WSETM: begin
				if (evt.op == OP_PLUS || evt.op == OP_MINUS) begin
					tgt = TGT_WATCH_HM;
					nh  = evt.watch_hours;
					nm  = evt.watch_minutes;
					if (st_q == ST_WSETH) begin
						nh = 5'(wrap_step({1'b0, evt.watch_hours}, HOUR_MAX, up));
					end else begin
						nm = wrap_step(evt.watch_minutes, MIN_MAX, up);
					end
				end else if (evt.op == OP_WATCH) begin
					if (st_q == ST_WSETH) begin
						st_d = ST_WSETM;
					end else begin
						tgt   = TGT_WATCH_CLR;
						set_d = 1'b0;
						st_d  = ST_SHOW;
					end
				end else if (evt.op == OP_SWATCH) begin
					set_d = 1'b0;
					st_d  = sw_tgt;
				end else if (evt.op == OP_ALARM) begin
					set_d = 1'b0;
					st_d  = al_tgt;
				end else if (evt.op == OP_TIMER) begin
					set_d = 1'b0;
					st_d  = tm_tgt;
				end
			end
			ST_SW_STOP, ST_SW_RUN, ST_SW_PAUSE: begin
				if (evt.op == OP_START && st_q != ST_SW_RUN) begin
					sws_d = SWS_RUNNING;
					if (st_q == ST_SW_STOP) begin
						act = ACT_SW_START;
					end
					st_d = ST_SW_RUN;
				end else if (evt.op == OP_STOP && st_q == ST_SW_RUN) begin
					sws_d = SWS_PAUSED;
					st_d  = ST_SW_PAUSE;
				end else if (evt.op == OP_STOP && st_q == ST_SW_PAUSE) begin
					sws_d = SWS_STOPPED;
					act   = ACT_SW_CLEAR;
					st_d  = ST_SW_STOP;
				end else if (evt.op == OP_WATCH || evt.op == OP_ALARM ||
						evt.op == OP_TIMER) begin
					swh_d = (st_q == ST_SW_RUN) ? SWH_RUN :
						(st_q == ST_SW_PAUSE) ? SWH_PAUSE : SWH_STOP;
					st_d = (evt.op == OP_WATCH) ? ST_SHOW :
						(evt.op == OP_ALARM) ? al_tgt : tm_tgt;
				end
			end
			ST_AL_SETH, ST_AL_SETM: begin
				if (evt.op == OP_ALARM) begin
					st_d = (st_q == ST_AL_SETH) ? ST_AL_SETM : ST_AL_SETH;
				end else if (evt.op == OP_START) begin
					if (alarm_later) begin
						arm_d = 1'b1;
						act   = ACT_AL_RING;
						st_d  = ST_AL_RUN;
					end
				end else if (evt.op == OP_PLUS || evt.op == OP_MINUS) begin
					if (st_q == ST_AL_SETH) begin
						alh_hr_d = 5'(wrap_step({1'b0, alh_hr_q}, HOUR_MAX, up));
					end else begin
						al_min_d = wrap_step(al_min_q, MIN_MAX, up);
					end
				end else if (evt.op == OP_WATCH || evt.op == OP_SWATCH ||
						evt.op == OP_TIMER) begin
					alh_d = (st_q == ST_AL_SETM) ? ALH_SETM : ALH_SETH;
					st_d = (evt.op == OP_WATCH) ? ST_SHOW :
						(evt.op == OP_SWATCH) ? sw_tgt : tm_tgt;
				end
			end
			ST_AL_RUN: begin
				if (evt.op == OP_TICK) begin
					// The ring ran out: the alarm is spent but stays flagged armed.
					if (evt.alarm_done) begin
						alh_hr_d = 5'd0;
						al_min_d = 6'd0;
						st_d     = ST_AL_SETH;
					end
				end else if (evt.op == OP_STOP) begin
					alh_hr_d = 5'd0;
					al_min_d = 6'd0;
					arm_d    = 1'b0;
					act      = ACT_AL_STOP;
					st_d     = ST_AL_SETH;
				end else if (evt.op == OP_WATCH || evt.op == OP_SWATCH ||
						evt.op == OP_TIMER) begin
					alh_d = ALH_RUN;
					st_d = (evt.op == OP_WATCH) ? ST_SHOW :
						(evt.op == OP_SWATCH) ? sw_tgt : tm_tgt;
				end
			end
			ST_TM_SETH, ST_TM_SETM, ST_TM_SETS: begin
				if (evt.op == OP_STOP) begin
					tgt  = TGT_TIMER_CLR;
					st_d = ST_TM_SETH;
				end else if (evt.op == OP_START) begin
					if (timer_nonzero) begin
						act  = ACT_TM_START;
						st_d = ST_TM_RUN;
					end
				end else if (evt.op == OP_PLUS || evt.op == OP_MINUS) begin
					tgt = TGT_TIMER_HMS;
					nh  = evt.timer_hours;
					nm  = evt.timer_minutes;
					ns  = evt.timer_seconds;
					if (st_q == ST_TM_SETH) begin
						nh = 5'(wrap_step({1'b0, evt.timer_hours}, HOUR_MAX, up));
					end else if (st_q == ST_TM_SETM) begin
						nm = wrap_step(evt.timer_minutes, MIN_MAX, up);
					end else begin
						ns = wrap_step(evt.timer_seconds, MIN_MAX, up);
					end
				end else if (evt.op == OP_TIMER) begin
					st_d = (st_q == ST_TM_SETH) ? ST_TM_SETM :
						(st_q == ST_TM_SETM) ? ST_TM_SETS : ST_TM_SETH;
				end else if (evt.op == OP_WATCH || evt.op == OP_SWATCH ||
						evt.op == OP_ALARM) begin
					tmh_d = TMH_SETH;
					st_d = (evt.op == OP_WATCH) ? ST_SHOW :
						(evt.op == OP_SWATCH) ? sw_tgt : al_tgt;
				end
			end
			ST_TM_RUN: begin
				if (evt.op == OP_STOP) begin
					act  = ACT_TM_STOP;
					tgt  = TGT_TIMER_CLR;
					st_d = ST_TM_SETH;
				end else if (evt.op == OP_WATCH || evt.op == OP_SWATCH ||
						evt.op == OP_ALARM) begin
					tmh_d = TMH_RUN;
					st_d = (evt.op == OP_WATCH) ? ST_SHOW :
						(evt.op == OP_SWATCH) ? sw_tgt : al_tgt;
				end
			end
			default: begin
				st_d = ST_SHOW;
			end
		endcase
	end

	always_comb begin
		res.state_code    = state_code_f(st_d);
		res.mode          = mode_f(st_d);
		res.watch_setting = set_d;
		res.swatch_run    = sws_d;
		res.alarm_armed   = arm_d;
		res.action        = act;
		res.write_target  = tgt;
		res.new_hours     = nh;
		res.new_minutes   = nm;
		res.new_seconds   = ns;
		res.alarm_hours   = alh_hr_d;
		res.alarm_minutes = al_min_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_SHOW;
			swh_q    <= SWH_STOP;
			alh_q    <= ALH_SETH;
			tmh_q    <= TMH_SETH;
			alh_hr_q <= 5'd0;
			al_min_q <= 6'd0;
			set_q    <= 1'b0;
			sws_q    <= SWS_STOPPED;
			arm_q    <= 1'b0;
		end else if (adv) begin
			st_q     <= st_d;
			swh_q    <= swh_d;
			alh_q    <= alh_d;
			tmh_q    <= tmh_d;
			alh_hr_q <= alh_hr_d;
			al_min_q <= al_min_d;
			set_q    <= set_d;
			sws_q    <= sws_d;
			arm_q    <= arm_d;
		end
	end

endmodule

[hdl/digital_watch_mode_controller_unit.sv]
// Digital watch mode controller. Top level: event input register, result
// register and handshakes. Depends on dwmc_pkg and dwmc_ctrl.
//
// Usage: one button or tick event is transferred on evt (evt_valid high,
// evt_stall low) together with the current watch and timer counter values.
// For each event exactly one result is transferred on res: the new state,
// mode, status flags, a start/stop action and a write command for the
// outside counters, plus the stored alarm time.
// The result is registered: an event passes the event register and then
// the result register, and waits in the event register while a stalled
// result is held.
// Throughput: one event per cycle unless the receiver stalls; the next-state
// logic between the two registers is a single pass, and the state updates as
// an event moves on. When the receiver stalls, the result holds and the event
// register still takes one more event before evt_stall rises.
// Reset (arst_n low) empties both registers and returns the controller to
// show time, stopwatch stopped, alarm 00:00 unarmed and timer set hours.
module digital_watch_mode_controller_unit import dwmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic s1_v_q;
	evt_t evt_s1;
	logic res_v_q;
	res_t res_q;
	res_t res_d;
	logic out_adv, adv, evt_take;

	assign out_adv   = !res_v_q || !res_stall;
	assign adv       = s1_v_q && out_adv;
	assign evt_stall = s1_v_q && !out_adv;
	assign evt_take  = evt_valid && !evt_stall;

	dwmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.evt    (evt_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (evt_take) begin
				s1_v_q <= 1'b1;
			end else if (adv) begin
				s1_v_q <= 1'b0;
			end
			if (out_adv) begin
				res_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			evt_s1 <= evt;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for digital_watch_mode_controller_unit: a directed table and random
// button/tick events; each result is checked against a typed expectation or an in-bench model.
// Depends on dwmc_pkg and the controller RTL only.
module tb import dwmc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Codes above OP_STOP are not buttons and must be ignored.
	localparam logic [3:0] OP_UNUSED_MAX = 4'd15;

	localparam int RAND_PER_PHASE = 340;

	typedef struct {
		evt_t ev;
		bit   typed;
		res_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// Model copy of the controller state, at reset values.
	logic [3:0] cur_state = SC_SHOW;
	logic [1:0] sw_hist = SWH_STOP;
	logic [1:0] al_hist = ALH_SETH;
	logic [2:0] tm_hist = TMH_SETH;
	logic [4:0] al_h = '0;
	logic [5:0] al_m = '0;
	logic       set_flag = 1'b0;
	logic [1:0] sw_stat = SWS_STOPPED;
	logic       armed = 1'b0;

	res_t     due_ctrl_out[$];
	dir_row_t dir_tab[$];
	int       fail_cnt = 0;
	int       snd_idle_pct = 0;
	int       rcv_idle_pct = 0;
	int       quiet_cnt = 0;

	digital_watch_mode_controller_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [5:0] step_val(logic [5:0] v, logic [5:0] top, logic up);
		if (up) begin
			return (v >= top) ? 6'd0 : v + 6'd1;
		end
		return (v == 6'd0 || v > top) ? top : v - 6'd1;
	endfunction

	// Target state when a mode button takes the watch into another mode.
	function automatic logic [3:0] enter_mode(logic [3:0] op);
		case (op)
			OP_WATCH:  return SC_SHOW;
			OP_SWATCH: return SC_SW_STOP + 4'(sw_hist);
			OP_ALARM:  return SC_AL_SETH + 4'(al_hist);
			default:   return (tm_hist == TMH_RUN) ? SC_TM_RUN : SC_TM_SETH;
		endcase
	endfunction

	function automatic res_t watch_ctrl_step(evt_t e);
		res_t       r;
		logic [3:0] nxt;
		logic       up;
		logic       adj;
		logic       leave_ok;
		logic       tm_nz;
		logic       al_later;
		r = '0;
		nxt = cur_state;
		up = (e.op == OP_PLUS);
		adj = (e.op == OP_PLUS || e.op == OP_MINUS);
		tm_nz = |{e.timer_hours, e.timer_minutes, e.timer_seconds};
		al_later = (al_h > e.watch_hours) ||
			(al_h == e.watch_hours && al_m > e.watch_minutes);
		case (cur_state)
			SC_SHOW: begin
				if (e.op == OP_WATCH) begin
					set_flag = 1'b1;
					nxt = SC_WSETH;
				end else if (e.op == OP_SWATCH || e.op == OP_ALARM || e.op == OP_TIMER) begin
					nxt = enter_mode(e.op);
				end
			end
			SC_WSETH, SC_WSETM: begin
				if (adj) begin
					r.write_target = TGT_WATCH_HM;
					r.new_hours = e.watch_hours;
					r.new_minutes = e.watch_minutes;
					if (cur_state == SC_WSETH) begin
						r.new_hours = 5'(step_val(6'(e.watch_hours), HOUR_MAX, up));
					end else begin
						r.new_minutes = step_val(e.watch_minutes, MIN_MAX, up);
					end
				end else if (e.op == OP_WATCH) begin
					if (cur_state == SC_WSETH) begin
						nxt = SC_WSETM;
					end else begin
						r.write_target = TGT_WATCH_CLR;
						set_flag = 1'b0;
						nxt = SC_SHOW;
					end
				end else if (e.op == OP_SWATCH || e.op == OP_ALARM || e.op == OP_TIMER) begin
					set_flag = 1'b0;
					nxt = enter_mode(e.op);
				end
			end
			SC_SW_STOP, SC_SW_RUN, SC_SW_PAUSE: begin
				leave_ok = (e.op == OP_WATCH || e.op == OP_ALARM || e.op == OP_TIMER);
				if (e.op == OP_START && cur_state != SC_SW_RUN) begin
					sw_stat = SWS_RUNNING;
					if (cur_state == SC_SW_STOP) begin
						r.action = ACT_SW_START;
					end
					nxt = SC_SW_RUN;
				end else if (e.op == OP_STOP && cur_state == SC_SW_RUN) begin
					sw_stat = SWS_PAUSED;
					nxt = SC_SW_PAUSE;
				end else if (e.op == OP_STOP && cur_state == SC_SW_PAUSE) begin
					sw_stat = SWS_STOPPED;
					r.action = ACT_SW_CLEAR;
					nxt = SC_SW_STOP;
				end else if (leave_ok) begin
					sw_hist = 2'(cur_state - SC_SW_STOP);
					nxt = enter_mode(e.op);
				end
			end
			SC_AL_SETH, SC_AL_SETM: begin
				leave_ok = (e.op == OP_WATCH || e.op == OP_SWATCH || e.op == OP_TIMER);
				if (e.op == OP_ALARM) begin
					nxt = (cur_state == SC_AL_SETH) ? SC_AL_SETM : SC_AL_SETH;
				end else if (e.op == OP_START) begin
					if (al_later) begin
						armed = 1'b1;
						r.action = ACT_AL_RING;
						nxt = SC_AL_RUN;
					end
				end else if (adj) begin
					if (cur_state == SC_AL_SETH) begin
						al_h = 5'(step_val(6'(al_h), HOUR_MAX, up));
					end else begin
						al_m = step_val(al_m, MIN_MAX, up);
					end
				end else if (leave_ok) begin
					al_hist = 2'(cur_state - SC_AL_SETH);
					nxt = enter_mode(e.op);
				end
			end
			SC_AL_RUN: begin
				leave_ok = (e.op == OP_WATCH || e.op == OP_SWATCH || e.op == OP_TIMER);
				if (e.op == OP_TICK) begin
					// The ring ran out: alarm time is cleared, but it stays armed.
					if (e.alarm_done) begin
						al_h = '0;
						al_m = '0;
						nxt = SC_AL_SETH;
					end
				end else if (e.op == OP_STOP) begin
					al_h = '0;
					al_m = '0;
					armed = 1'b0;
					r.action = ACT_AL_STOP;
					nxt = SC_AL_SETH;
				end else if (leave_ok) begin
					al_hist = ALH_RUN;
					nxt = enter_mode(e.op);
				end
			end
			SC_TM_SETH, SC_TM_SETM, SC_TM_SETS: begin
				leave_ok = (e.op == OP_WATCH || e.op == OP_SWATCH || e.op == OP_ALARM);
				if (e.op == OP_STOP) begin
					r.write_target = TGT_TIMER_CLR;
					nxt = SC_TM_SETH;
				end else if (e.op == OP_START) begin
					if (tm_nz) begin
						r.action = ACT_TM_START;
						nxt = SC_TM_RUN;
					end
				end else if (adj) begin
					r.write_target = TGT_TIMER_HMS;
					r.new_hours = e.timer_hours;
					r.new_minutes = e.timer_minutes;
					r.new_seconds = e.timer_seconds;
					if (cur_state == SC_TM_SETH) begin
						r.new_hours = 5'(step_val(6'(e.timer_hours), HOUR_MAX, up));
					end else if (cur_state == SC_TM_SETM) begin
						r.new_minutes = step_val(e.timer_minutes, MIN_MAX, up);
					end else begin
						r.new_seconds = step_val(e.timer_seconds, MIN_MAX, up);
					end
				end else if (e.op == OP_TIMER) begin
					nxt = (cur_state == SC_TM_SETS) ? SC_TM_SETH : cur_state + 4'd1;
				end else if (leave_ok) begin
					tm_hist = TMH_SETH;
					nxt = enter_mode(e.op);
				end
			end
			SC_TM_RUN: begin
				if (e.op == OP_STOP) begin
					r.action = ACT_TM_STOP;
					r.write_target = TGT_TIMER_CLR;
					nxt = SC_TM_SETH;
				end else if (e.op == OP_WATCH || e.op == OP_SWATCH || e.op == OP_ALARM) begin
					tm_hist = TMH_RUN;
					nxt = enter_mode(e.op);
				end
			end
			default: begin
				nxt = SC_SHOW;
			end
		endcase
		cur_state = nxt;
		r.state_code = nxt;
		if (nxt <= SC_WSETM) begin
			r.mode = MODE_WATCH;
		end else if (nxt <= SC_SW_PAUSE) begin
			r.mode = MODE_SWATCH;
		end else if (nxt <= SC_AL_RUN) begin
			r.mode = MODE_ALARM;
		end else begin
			r.mode = MODE_TIMER;
		end
		r.watch_setting = set_flag;
		r.swatch_run = sw_stat;
		r.alarm_armed = armed;
		r.alarm_hours = al_h;
		r.alarm_minutes = al_m;
		return r;
	endfunction

	function automatic evt_t mk_event(logic [3:0] op, logic [4:0] wh, logic [5:0] wm,
			logic [4:0] th, logic [5:0] tmn, logic [5:0] ts, logic dn);
		evt_t e;
		e.op = op;
		e.watch_hours = wh;
		e.watch_minutes = wm;
		e.timer_hours = th;
		e.timer_minutes = tmn;
		e.timer_seconds = ts;
		e.alarm_done = dn;
		return e;
	endfunction

	function automatic evt_t rand_event();
		evt_t e;
		if ($urandom_range(99) < 5) begin
			e.op = 4'($urandom_range(OP_UNUSED_MAX, OP_STOP + 4'd1));
		end else begin
			e.op = 4'($urandom_range(OP_STOP, OP_TICK));
		end
		// Mostly in-range counter values, now and then anything the field can hold.
		e.watch_hours = 5'(($urandom_range(99) < 10) ? $urandom_range(31) :
			$urandom_range(HOUR_MAX));
		e.watch_minutes = 6'(($urandom_range(99) < 10) ? $urandom_range(63) :
			$urandom_range(MIN_MAX));
		e.timer_hours = 5'(($urandom_range(99) < 10) ? $urandom_range(31) :
			$urandom_range(HOUR_MAX));
		e.timer_minutes = 6'(($urandom_range(99) < 10) ? $urandom_range(63) :
			$urandom_range(MIN_MAX));
		e.timer_seconds = 6'(($urandom_range(99) < 10) ? $urandom_range(63) :
			$urandom_range(MIN_MAX));
		if ($urandom_range(99) < 10) begin
			e.timer_hours = '0;
			e.timer_minutes = '0;
			e.timer_seconds = '0;
		end
		e.alarm_done = 1'($urandom_range(1));
		return e;
	endfunction

	task automatic add_row(evt_t e, bit typed = 1'b0, res_t want = '0);
		dir_row_t row;
		row.ev = e;
		row.typed = typed;
		row.want = want;
		dir_tab.push_back(row);
	endtask

	task automatic send_event(evt_t e, bit typed, res_t want);
		res_t pred;
		while (quiet_cnt == 0 && $urandom_range(99) < snd_idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		pred = watch_ctrl_step(e);
		due_ctrl_out.push_back(typed ? want : pred);
		evt <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic chk_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_result(res_t want, res_t got);
		chk_field("state_code", want.state_code, got.state_code);
		chk_field("mode", want.mode, got.mode);
		chk_field("watch_setting", want.watch_setting, got.watch_setting);
		chk_field("swatch_run", want.swatch_run, got.swatch_run);
		chk_field("alarm_armed", want.alarm_armed, got.alarm_armed);
		chk_field("action", want.action, got.action);
		chk_field("write_target", want.write_target, got.write_target);
		chk_field("new_hours", want.new_hours, got.new_hours);
		chk_field("new_minutes", want.new_minutes, got.new_minutes);
		chk_field("new_seconds", want.new_seconds, got.new_seconds);
		chk_field("alarm_hours", want.alarm_hours, got.alarm_hours);
		chk_field("alarm_minutes", want.alarm_minutes, got.alarm_minutes);
	endtask

	// Result side: check each transfer, then choose the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_ctrl_out.size() == 0) begin
					$error("result transfer with no event outstanding");
					fail_cnt++;
				end else begin
					check_result(due_ctrl_out.pop_front(), res);
				end
			end
			if (quiet_cnt != 0) begin
				quiet_cnt <= quiet_cnt - 1;
				res_stall <= 1'b0;
			end else begin
				if ($urandom_range(99) < 2) begin
					quiet_cnt <= $urandom_range(40, 10);
				end
				res_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	initial begin
		// Reset state, unknown op, and the wrap extremes of watch setting.
		add_row(mk_event(OP_TICK, '0, '0, '0, '0, '0, 1'b0), 1'b1, '0);
		add_row(mk_event(OP_UNUSED_MAX, 5'd31, 6'd63, 5'd31, 6'd63, 6'd63, 1'b1), 1'b1, '0);
		add_row(mk_event(OP_WATCH, '0, '0, '0, '0, '0, 1'b0), 1'b1,
			'{state_code: SC_WSETH, watch_setting: 1'b1, default: '0});
		add_row(mk_event(OP_PLUS, 5'd23, 6'd59, '0, '0, '0, 1'b0), 1'b1,
			'{state_code: SC_WSETH, watch_setting: 1'b1, write_target: TGT_WATCH_HM,
			new_minutes: 6'd59, default: '0});
		add_row(mk_event(OP_MINUS, '0, '0, '0, '0, '0, 1'b0), 1'b1,
			'{state_code: SC_WSETH, watch_setting: 1'b1, write_target: TGT_WATCH_HM,
			new_hours: 5'd23, default: '0});
		add_row(mk_event(OP_MINUS, 5'd31, 6'd63, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_WATCH, 5'd12, 6'd30, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_MINUS, 5'd12, 6'd63, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_WATCH, 5'd12, 6'd30, '0, '0, '0, 1'b0));
		// Stopwatch start, pause, clear, then leave it paused.
		add_row(mk_event(OP_SWATCH, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_START, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_STOP, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_STOP, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_START, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_STOP, '0, '0, '0, '0, '0, 1'b0));
		// Timer: start refused at zero, wrap of each field, clear, start.
		add_row(mk_event(OP_TIMER, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_START, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_PLUS, '0, '0, 5'd23, 6'd59, 6'd59, 1'b0));
		add_row(mk_event(OP_TIMER, '0, '0, 5'd1, 6'd2, 6'd3, 1'b0));
		add_row(mk_event(OP_MINUS, '0, '0, 5'd1, 6'd0, 6'd3, 1'b0));
		add_row(mk_event(OP_TIMER, '0, '0, 5'd1, 6'd2, 6'd3, 1'b0));
		add_row(mk_event(OP_PLUS, '0, '0, 5'd1, 6'd2, 6'd63, 1'b0));
		add_row(mk_event(OP_STOP, '0, '0, 5'd1, 6'd2, 6'd3, 1'b0));
		add_row(mk_event(OP_START, '0, '0, '0, '0, 6'd1, 1'b0));
		// Alarm: arm refused at equal time, armed when later, ring runs out.
		add_row(mk_event(OP_ALARM, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_MINUS, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_START, 5'd23, 6'd0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_START, 5'd22, 6'd59, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_TICK, 5'd22, 6'd59, '0, '0, '0, 1'b1));
		// History: stopwatch returns paused, timer returns running.
		add_row(mk_event(OP_SWATCH, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_TIMER, '0, '0, '0, '0, '0, 1'b0));
		add_row(mk_event(OP_STOP, '0, '0, '0, '0, '0, 1'b0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 6;
		rcv_idle_pct = 67;
		foreach (dir_tab[i]) begin
			send_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 67 : 0;
			rcv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 6 : 0;
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				send_event(rand_event(), 1'b0, '0);
			end
			// Hold the sender off until the controller has drained.
			evt_valid <= 1'b0;
			while (due_ctrl_out.size() != 0) begin
				@(posedge clk);
			end
		end

		repeat (10) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("[digital_watch_mode_controller_unit] OK");
		end else begin
			$display("[digital_watch_mode_controller_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[digital_watch_mode_controller_unit] ERROR");
		$finish;
	end

endmodule
